@@ rtl/tone_curve_lut_interpolator_assert.svh @@
// Assertion helpers for the tone curve RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef TONE_CURVE_LUT_INTERPOLATOR_ASSERT_SVH
`define TONE_CURVE_LUT_INTERPOLATOR_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define TCLI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tone curve assertion failed");

// Check that a condition implies another in the next cycle.
`define TCLI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tone curve assertion failed");

`endif

@@ rtl/tcli_pkg.sv @@
package tcli_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES   = 257;
    localparam int ADDR_W          = 9;
    localparam int LEVEL_W         = 8;
    localparam int LUT_IDX_W       = 8;

    // Sample depth
    localparam int SAMPLE_W        = 16;
    localparam int BITS_W          = 5;
    localparam int MIN_SAMPLE_BITS = 8;
    localparam int MAX_SAMPLE_BITS = 16;
    localparam int SHIFT_W         = 4;
    localparam int FRAC_W          = 8;
    localparam int STEP_W          = 9;
    localparam int ACC_W           = 17;

    // Configuration port
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 5;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE   = 4'd1;

    // Commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MAP  = 1'b1;

    // Control from the top level to each channel lane
    typedef struct packed {
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [LEVEL_W-1:0]  wr_data;
        logic                adv1;
        logic                adv2;
        logic [SHIFT_W-1:0]  shift;
    } lane_ctrl_t;

endpackage

@@ rtl/tcli_channels.sv @@
// Request channel: load or map commands
interface tcli_req_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic [tcli_pkg::ADDR_W-1:0]       entry_index;
    logic [tcli_pkg::LEVEL_W-1:0]      entry_value;
    logic [tcli_pkg::SAMPLE_W-1:0]     sample_red;
    logic [tcli_pkg::SAMPLE_W-1:0]     sample_green;
    logic [tcli_pkg::SAMPLE_W-1:0]     sample_blue;

    modport source (output valid, command, entry_index, entry_value,
                    output sample_red, sample_green, sample_blue, input ready);
    modport sink   (input valid, command, entry_index, entry_value,
                    input sample_red, sample_green, sample_blue, output ready);
endinterface

// Result channel: mapped display levels
interface tcli_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [tcli_pkg::LEVEL_W-1:0]      display_red;
    logic [tcli_pkg::LEVEL_W-1:0]      display_green;
    logic [tcli_pkg::LEVEL_W-1:0]      display_blue;

    modport source (output valid, display_red, display_green, display_blue, input ready);
    modport sink   (input valid, display_red, display_green, display_blue, output ready);
endinterface

// Configuration write channel
interface tcli_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tcli_pkg::CFG_IDX_W-1:0]    index;
    logic [tcli_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/tcli_lane.sv @@
// One color channel: private copy of the curve table, neighbor read,
// weighted blend and final shift.
module tcli_lane (
    input  logic                              clk,
    input  tcli_pkg::lane_ctrl_t              ctrl,
    input  logic [tcli_pkg::SAMPLE_W-1:0]     sample,
    output logic [tcli_pkg::LEVEL_W-1:0]      level
);

    logic [tcli_pkg::LEVEL_W-1:0]   mem [0:tcli_pkg::TABLE_ENTRIES-1];

    logic [tcli_pkg::SAMPLE_W-1:0]  masked;
    logic [tcli_pkg::SAMPLE_W-1:0]  frac_full;
    logic [tcli_pkg::SAMPLE_W-1:0]  idx_full;
    logic [tcli_pkg::LUT_IDX_W-1:0] lo_idx;
    logic [tcli_pkg::ADDR_W-1:0]    lo_addr;
    logic [tcli_pkg::ADDR_W-1:0]    hi_addr;

    logic [tcli_pkg::LEVEL_W-1:0]   rd_lo_reg;
    logic [tcli_pkg::LEVEL_W-1:0]   rd_hi_reg;
    logic [tcli_pkg::FRAC_W-1:0]    frac1_reg;
    logic [tcli_pkg::SHIFT_W-1:0]   shift1_reg;

    logic [tcli_pkg::STEP_W-1:0]    step;
    logic [tcli_pkg::STEP_W-1:0]    w_lo;
    logic [tcli_pkg::ACC_W-1:0]     prod_lo;
    logic [tcli_pkg::ACC_W-1:0]     prod_hi;
    logic [tcli_pkg::ACC_W-1:0]     acc_next;
    logic [tcli_pkg::ACC_W-1:0]     acc_reg;
    logic [tcli_pkg::SHIFT_W-1:0]   shift2_reg;

    // Split the sample into table index and blend weight
    always_comb
    begin
        masked    = sample & ~({tcli_pkg::SAMPLE_W{1'b1}}
                               << ({1'b0, ctrl.shift} + 5'd8));
        frac_full = masked & ~({tcli_pkg::SAMPLE_W{1'b1}} << ctrl.shift);
        idx_full  = masked >> ctrl.shift;
        lo_idx    = idx_full[tcli_pkg::LUT_IDX_W-1:0];
        lo_addr   = {1'b0, lo_idx};
        hi_addr   = lo_addr + 9'd1;
    end

    // Write table entries, read both neighbors
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.adv1)
        begin
            rd_lo_reg  <= mem[lo_addr];
            rd_hi_reg  <= mem[hi_addr];
            frac1_reg  <= frac_full[tcli_pkg::FRAC_W-1:0];
            shift1_reg <= ctrl.shift;
        end
    end

    // Blend the two neighbors
    always_comb
    begin
        step     = 9'd1 << shift1_reg;
        w_lo     = step - {1'b0, frac1_reg};
        prod_lo  = 17'(rd_lo_reg) * 17'(w_lo);
        prod_hi  = 17'(rd_hi_reg) * 17'(frac1_reg);
        acc_next = prod_lo + prod_hi;
    end

    // Hold the blend for the final shift
    always_ff @(posedge clk)
    begin
        if (ctrl.adv2)
        begin
            acc_reg    <= acc_next;
            shift2_reg <= shift1_reg;
        end
    end

    // Scale back to a display level
    assign level = tcli_pkg::LEVEL_W'(acc_reg >> shift2_reg);

endmodule

@@ rtl/tone_curve_lut_interpolator.sv @@
// A map result passes through three register stages: table read, blend,
// output.
// Throughput: one request per clock while the result is not stalled; a stalled result holds each full stage behind it.
// Load requests write the curve table and produce no result.
// Reset: control clears at once, sample_bits returns to 8 and gray_mode to 0;
// the curve table is not cleared and must be loaded before use.
module tone_curve_lut_interpolator (
    input  logic         clk,
    input  logic         rst_n,
    tcli_req_if.sink     req,
    tcli_rsp_if.source   rsp,
    tcli_cfg_if.sink     cfg
);

    `include "tone_curve_lut_interpolator_assert.svh"

    logic [tcli_pkg::BITS_W-1:0]    sample_bits_reg;
    logic                           gray_mode_reg;
    logic [tcli_pkg::BITS_W-1:0]    bits_eff;
    logic [tcli_pkg::SHIFT_W-1:0]   shift;

    logic                           adv1;
    logic                           adv2;
    logic                           adv3;
    logic                           req_fire;
    logic                           map_fire;
    logic                           v1_reg;
    logic                           v2_reg;
    logic                           out_valid_reg;
    logic [tcli_pkg::LEVEL_W-1:0]   display_red_reg;
    logic [tcli_pkg::LEVEL_W-1:0]   display_green_reg;
    logic [tcli_pkg::LEVEL_W-1:0]   display_blue_reg;

    logic [tcli_pkg::LEVEL_W-1:0]   level_red;
    logic [tcli_pkg::LEVEL_W-1:0]   level_green;
    logic [tcli_pkg::LEVEL_W-1:0]   level_blue;

    tcli_pkg::lane_ctrl_t           lane_ctrl;

    // Accept configuration writes at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_bits_reg <= 5'd8;
            gray_mode_reg   <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                tcli_pkg::REG_SAMPLE_BITS: sample_bits_reg <= cfg.data;
                tcli_pkg::REG_GRAY_MODE:   gray_mode_reg   <= cfg.data[0];
                default:                   ;
            endcase
        end
    end

    // Clamp the depth to the supported range
    always_comb
    begin
        if (sample_bits_reg < 5'(tcli_pkg::MIN_SAMPLE_BITS))
            bits_eff = 5'(tcli_pkg::MIN_SAMPLE_BITS);
        else if (sample_bits_reg > 5'(tcli_pkg::MAX_SAMPLE_BITS))
            bits_eff = 5'(tcli_pkg::MAX_SAMPLE_BITS);
        else
            bits_eff = sample_bits_reg;
        shift = tcli_pkg::SHIFT_W'(bits_eff - 5'd8);
    end

    // Advance each stage when the next one has room
    assign adv3      = !out_valid_reg || rsp.ready;
    assign adv2      = !v2_reg || adv3;
    assign adv1      = !v1_reg || adv2;
    assign req.ready = adv1;
    assign req_fire  = req.valid && adv1;
    assign map_fire  = req_fire && (req.command == tcli_pkg::CMD_MAP);

    // Drive the lanes; loads and maps never share a cycle, so no forwarding
    always_comb
    begin
        lane_ctrl.wr_en   = req_fire && (req.command == tcli_pkg::CMD_LOAD)
                            && (req.entry_index < 9'(tcli_pkg::TABLE_ENTRIES));
        lane_ctrl.wr_addr = req.entry_index;
        lane_ctrl.wr_data = req.entry_value;
        lane_ctrl.adv1    = adv1;
        lane_ctrl.adv2    = adv2;
        lane_ctrl.shift   = shift;
    end

    tcli_lane u_lane_red (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .sample (req.sample_red),
        .level  (level_red)
    );

    tcli_lane u_lane_green (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .sample (req.sample_green),
        .level  (level_green)
    );

    tcli_lane u_lane_blue (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .sample (req.sample_blue),
        .level  (level_blue)
    );

    // Track map requests through the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= map_fire;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                out_valid_reg <= v2_reg;
        end
    end

    // Capture the result; copy red in gray mode
    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg)
        begin
            display_red_reg   <= level_red;
            display_green_reg <= gray_mode_reg ? level_red : level_green;
            display_blue_reg  <= gray_mode_reg ? level_red : level_blue;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.display_red   = display_red_reg;
    assign rsp.display_green = display_green_reg;
    assign rsp.display_blue  = display_blue_reg;

    `TCLI_ASSERT_NEXT(a_load_no_result, req_fire && (req.command == tcli_pkg::CMD_LOAD), !v1_reg)
    `TCLI_ASSERT_NEXT(a_map_enters, map_fire, v1_reg)
    `TCLI_ASSERT_SAME(a_stall_full, !req.ready, v1_reg && v2_reg && rsp.valid && !rsp.ready)
    `TCLI_ASSERT_SAME(a_result_source, $rose(rsp.valid), $past(v2_reg))

endmodule
